[rtl/bbct_pkg.sv]
package bbct_pkg;

    // request actions
    typedef enum logic [1:0] {
        ACT_GET      = 2'd0,
        ACT_RELEASE  = 2'd1,
        ACT_DIRTY    = 2'd2,
        ACT_UPTODATE = 2'd3
    } action_t;

    // response status codes
    typedef enum logic [2:0] {
        ST_HIT    = 3'd0,
        ST_ALLOC  = 3'd1,
        ST_NOFREE = 3'd2,
        ST_BADREL = 3'd3,
        ST_FULL   = 3'd4
    } status_t;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_SCAN   = 2'd1,
        S_FINISH = 2'd2
    } state_t;

    localparam logic [7:0] COUNT_MAX = 8'hFF;

    // request beat
    typedef struct packed {
        action_t     action;
        logic [7:0]  device;
        logic [31:0] block_number;
        logic [3:0]  slot;
    } req_t;

    // response beat
    typedef struct packed {
        status_t    status;
        logic [3:0] entry;
        logic       needs_read;
        logic       wake_waiters;
    } rsp_t;

    // one tag entry as held in the tag memory
    typedef struct packed {
        logic [7:0]  device;
        logic [31:0] blk;
        logic [7:0]  count;
        logic        dirty;
        logic        uptodate;
    } entry_rec_t;

endpackage

[rtl/block_buffer_cache_tags.sv]
// Tag and policy manager for a block buffer cache.
// Request channel: in_valid / in_ready carrying req (action, device,
// block_number, slot). Response channel: out_valid / out_ready carrying rsp
// (status, entry, needs_read, wake_waiters). Every request beat yields
// exactly one response beat, in order.
// A get walks the tag memory one entry per cycle through its single read
// port, looking for a tag match and the cheapest free entry at once; the
// request port stays busy until the scan is over and the response is
// registered. Release and the two mark actions read one entry and write it
// back; the request port is busy only while they do so.
// The response sits in an output register; the block takes the next request
// while it waits, and only holds in its final step if the previous response
// has still not been taken by the receiver.
// Reset clears one valid flag per entry; an entry never written since reset
// reads as all zero (empty tags, count zero, no marks), so no clearing pass
// is needed and the block is ready right after reset.
module block_buffer_cache_tags #(
    parameter int ENTRIES = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  bbct_pkg::req_t  req,
    output logic            out_valid,
    input  logic            out_ready,
    output bbct_pkg::rsp_t  rsp
);

    localparam int IW = $clog2(ENTRIES);
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
    localparam logic [IW:0]   DEPTH    = (IW+1)'(ENTRIES);

    // tag memory, no reset; validity held in flops
    bbct_pkg::entry_rec_t mem [ENTRIES];
    bbct_pkg::entry_rec_t rdata_reg;
    logic                 rd_ok_reg;
    logic [ENTRIES-1:0]   ent_valid_reg;

    bbct_pkg::state_t     state_reg, state_next;
    bbct_pkg::req_t       req_reg, req_next;
    logic [IW:0]          iss_reg, iss_next;
    logic                 rd_live_reg, rd_live_next;
    logic [IW-1:0]        rd_idx_reg, rd_idx_next;
    logic                 found_reg, found_next;
    logic [IW-1:0]        hit_idx_reg, hit_idx_next;
    bbct_pkg::entry_rec_t hit_rec_reg, hit_rec_next;
    logic                 free_reg, free_next;
    logic [IW-1:0]        best_idx_reg, best_idx_next;
    logic [1:0]           best_cost_reg, best_cost_next;
    logic                 out_valid_reg, out_valid_next;
    bbct_pkg::rsp_t       rsp_reg, rsp_next;

    logic                 rd_en;
    logic [IW-1:0]        rd_addr;
    logic                 wr_en;
    logic [IW-1:0]        wr_idx;
    bbct_pkg::entry_rec_t wr_rec;
    bbct_pkg::entry_rec_t eff;
    logic [1:0]           eff_cost;
    logic                 slot_ok_in;
    logic                 slot_ok_req;

    assign eff         = rd_ok_reg ? rdata_reg : '0;
    assign eff_cost    = {eff.dirty, eff.uptodate};
    assign slot_ok_in  = 32'(req.slot) < ENTRIES;
    assign slot_ok_req = 32'(req_reg.slot) < ENTRIES;

    assign out_valid = out_valid_reg;
    assign rsp       = rsp_reg;

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_rec;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // entry valid flags and read qualifier
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg <= '0;
            rd_ok_reg     <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                ent_valid_reg[wr_idx] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_ok_reg <= ent_valid_reg[rd_addr];
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bbct_pkg::S_IDLE;
            iss_reg       <= '0;
            rd_live_reg   <= 1'b0;
            found_reg     <= 1'b0;
            free_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iss_reg       <= iss_next;
            rd_live_reg   <= rd_live_next;
            found_reg     <= found_next;
            free_reg      <= free_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        rd_idx_reg    <= rd_idx_next;
        hit_idx_reg   <= hit_idx_next;
        hit_rec_reg   <= hit_rec_next;
        best_idx_reg  <= best_idx_next;
        best_cost_reg <= best_cost_next;
        rsp_reg       <= rsp_next;
    end

    // sequencer: next state, memory control and response
    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        iss_next       = iss_reg;
        rd_live_next   = 1'b0;
        found_next     = found_reg;
        hit_idx_next   = hit_idx_reg;
        hit_rec_next   = hit_rec_reg;
        free_next      = free_reg;
        best_idx_next  = best_idx_reg;
        best_cost_next = best_cost_reg;
        out_valid_next = out_valid_reg && !out_ready;
        rsp_next       = rsp_reg;
        in_ready       = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = iss_reg[IW-1:0];
        wr_en          = 1'b0;
        wr_idx         = IW'(req_reg.slot);
        wr_rec         = eff;

        case (state_reg)
            bbct_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    req_next   = req;
                    iss_next   = '0;
                    found_next = 1'b0;
                    free_next  = 1'b0;
                    if (req.action == bbct_pkg::ACT_GET)
                    begin
                        state_next = bbct_pkg::S_SCAN;
                    end
                    else
                    begin
                        // fetch the addressed entry right away
                        rd_en      = slot_ok_in;
                        rd_addr    = IW'(req.slot);
                        state_next = bbct_pkg::S_FINISH;
                    end
                end
            end

            bbct_pkg::S_SCAN:
            begin
                // issue one read per cycle
                if (iss_reg < DEPTH)
                begin
                    rd_en        = 1'b1;
                    iss_next     = iss_reg + 1'b1;
                    rd_live_next = 1'b1;
                end
                // check the entry read last cycle
                if (rd_live_reg)
                begin
                    if (!found_reg && eff.device == req_reg.device &&
                        eff.blk == req_reg.block_number)
                    begin
                        found_next   = 1'b1;
                        hit_idx_next = rd_idx_reg;
                        hit_rec_next = eff;
                    end
                    if (eff.count == 8'd0 && (!free_reg || eff_cost < best_cost_reg))
                    begin
                        free_next      = 1'b1;
                        best_idx_next  = rd_idx_reg;
                        best_cost_next = eff_cost;
                    end
                    if (rd_idx_reg == LAST_IDX)
                    begin
                        state_next = bbct_pkg::S_FINISH;
                    end
                end
            end

            bbct_pkg::S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next        = 1'b1;
                    state_next            = bbct_pkg::S_IDLE;
                    rsp_next.status       = bbct_pkg::ST_HIT;
                    rsp_next.entry        = req_reg.slot;
                    rsp_next.needs_read   = 1'b0;
                    rsp_next.wake_waiters = 1'b0;
                    if (req_reg.action == bbct_pkg::ACT_GET)
                    begin
                        if (found_reg)
                        begin
                            rsp_next.entry      = 4'(hit_idx_reg);
                            rsp_next.needs_read = !hit_rec_reg.uptodate;
                            if (hit_rec_reg.count == bbct_pkg::COUNT_MAX)
                            begin
                                rsp_next.status = bbct_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en        = 1'b1;
                                wr_idx       = hit_idx_reg;
                                wr_rec       = hit_rec_reg;
                                wr_rec.count = hit_rec_reg.count + 8'd1;
                            end
                        end
                        else if (free_reg)
                        begin
                            // retag the cheapest free entry
                            rsp_next.status     = bbct_pkg::ST_ALLOC;
                            rsp_next.entry      = 4'(best_idx_reg);
                            rsp_next.needs_read = 1'b1;
                            wr_en               = 1'b1;
                            wr_idx              = best_idx_reg;
                            wr_rec.device       = req_reg.device;
                            wr_rec.blk          = req_reg.block_number;
                            wr_rec.count        = 8'd1;
                            wr_rec.dirty        = 1'b0;
                            wr_rec.uptodate     = 1'b0;
                        end
                        else
                        begin
                            rsp_next.status = bbct_pkg::ST_NOFREE;
                            rsp_next.entry  = 4'd0;
                        end
                    end
                    else if (!slot_ok_req)
                    begin
                        rsp_next.status = bbct_pkg::ST_BADREL;
                    end
                    else
                    begin
                        case (req_reg.action)
                            bbct_pkg::ACT_RELEASE:
                            begin
                                if (eff.count == 8'd0)
                                begin
                                    rsp_next.status = bbct_pkg::ST_BADREL;
                                end
                                else
                                begin
                                    wr_en                 = 1'b1;
                                    wr_rec.count          = eff.count - 8'd1;
                                    rsp_next.wake_waiters = (eff.count == 8'd1);
                                end
                            end
                            bbct_pkg::ACT_DIRTY:
                            begin
                                wr_en        = 1'b1;
                                wr_rec.dirty = 1'b1;
                            end
                            default:
                            begin
                                wr_en           = 1'b1;
                                wr_rec.uptodate = 1'b1;
                            end
                        endcase
                    end
                end
            end

            default:
            begin
                state_next = bbct_pkg::S_IDLE;
            end
        endcase

        // remember which entry the pending read returns
        rd_idx_next = rd_en ? rd_addr : rd_idx_reg;
    end

    // busy after every accepted request
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted twice in a row");

    // memory is only written in the final step
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> state_reg == bbct_pkg::S_FINISH)
        else $error("tag write outside final step");

    // a new allocation always needs a disk read
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rsp.status == bbct_pkg::ST_ALLOC |-> rsp.needs_read)
        else $error("allocation without needs_read");

    // waiters are only woken by a good release
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rsp.wake_waiters |-> rsp.status == bbct_pkg::ST_HIT)
        else $error("wake on a failed action");

    // a full cache answers with a zero entry
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rsp.status == bbct_pkg::ST_NOFREE |->
            rsp.entry == 4'd0 && !rsp.needs_read)
        else $error("no-free response carries an entry");

endmodule

[tb/tb.sv]
module tb;

    localparam int CACHE_ENTRIES = 16;

    // one row of the directed table
    typedef struct {
        bbct_pkg::req_t item;
        bit             typed;
        bbct_pkg::rsp_t result;
    } stim_row_t;

    logic           clk;
    logic           rst_n = 1'b0;
    logic           in_valid = 1'b0;
    logic           in_ready;
    bbct_pkg::req_t req = '0;
    logic           out_valid;
    logic           out_ready = 1'b0;
    bbct_pkg::rsp_t rsp;

    // shadow copy of the tag store
    logic [7:0]  cache_dev [CACHE_ENTRIES];
    logic [31:0] cache_blk [CACHE_ENTRIES];
    logic [7:0]  cache_refs [CACHE_ENTRIES];
    logic        cache_dirty [CACHE_ENTRIES];
    logic        cache_uptodate [CACHE_ENTRIES];

    bbct_pkg::rsp_t pending_rsp [$];
    stim_row_t      directed_rows [$];
    int             error_count = 0;
    int             tx_idle_pct = 0;
    int             rx_idle_pct = 0;
    int             rx_hold = 0;

    block_buffer_cache_tags #(
        .ENTRIES (CACHE_ENTRIES)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req       (req),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .rsp       (rsp)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // watchdog
    initial
    begin
        #200000;
        $display("[block_buffer_cache_tags] ERROR");
        $finish;
    end

    // apply one request to the shadow store and return its response
    function automatic bbct_pkg::rsp_t apply_request(input bbct_pkg::req_t r);
        bbct_pkg::rsp_t o;
        int   hit;
        int   pick;
        o = '0;
        o.status = bbct_pkg::ST_HIT;
        o.entry = r.slot;
        case (r.action)
            bbct_pkg::ACT_GET:
            begin
                hit = -1;
                for (int k = 0; k < CACHE_ENTRIES; k++)
                    if (hit < 0 && cache_dev[k] == r.device &&
                        cache_blk[k] == r.block_number)
                        hit = k;
                if (hit >= 0)
                begin
                    o.entry = 4'(hit);
                    o.needs_read = !cache_uptodate[hit];
                    if (cache_refs[hit] == bbct_pkg::COUNT_MAX)
                        o.status = bbct_pkg::ST_FULL;
                    else
                        cache_refs[hit] = cache_refs[hit] + 8'd1;
                end
                else
                begin
                    // cheapest free entry, lowest index on ties
                    pick = -1;
                    for (int k = 0; k < CACHE_ENTRIES; k++)
                        if (cache_refs[k] == 8'd0 && (pick < 0 ||
                            {cache_dirty[k], cache_uptodate[k]} <
                            {cache_dirty[pick], cache_uptodate[pick]}))
                            pick = k;
                    if (pick < 0)
                    begin
                        o.status = bbct_pkg::ST_NOFREE;
                        o.entry = 4'd0;
                    end
                    else
                    begin
                        o.status = bbct_pkg::ST_ALLOC;
                        o.entry = 4'(pick);
                        o.needs_read = 1'b1;
                        cache_refs[pick] = 8'd1;
                        cache_dirty[pick] = 1'b0;
                        cache_uptodate[pick] = 1'b0;
                        cache_dev[pick] = r.device;
                        cache_blk[pick] = r.block_number;
                    end
                end
            end
            bbct_pkg::ACT_RELEASE:
            begin
                if (cache_refs[r.slot] == 8'd0)
                    o.status = bbct_pkg::ST_BADREL;
                else
                begin
                    cache_refs[r.slot] = cache_refs[r.slot] - 8'd1;
                    o.wake_waiters = (cache_refs[r.slot] == 8'd0);
                end
            end
            bbct_pkg::ACT_DIRTY:
                cache_dirty[r.slot] = 1'b1;
            default:
                cache_uptodate[r.slot] = 1'b1;
        endcase
        return o;
    endfunction

    // random request, mostly aimed at live tags and held entries
    function automatic bbct_pkg::req_t random_request();
        bbct_pkg::req_t r;
        int   sel;
        int   sub;
        int   start;
        int   k;
        r.device = 8'($urandom);
        r.block_number = $urandom;
        r.slot = 4'($urandom);
        sel = $urandom_range(0, 99);
        sub = $urandom_range(0, 99);
        if (sel < 40)
        begin
            r.action = bbct_pkg::ACT_GET;
            if (sub < 50)
            begin
                k = $urandom_range(0, CACHE_ENTRIES - 1);
                r.device = cache_dev[k];
                r.block_number = cache_blk[k];
            end
            else if (sub < 62)
            begin
                r.device = 8'd0;
                r.block_number = $urandom_range(0, 3);
            end
            else if (sub < 80)
                r.block_number = $urandom_range(0, 15);
        end
        else if (sel < 76)
        begin
            r.action = bbct_pkg::ACT_RELEASE;
            if (sub < 85)
            begin
                start = $urandom_range(0, CACHE_ENTRIES - 1);
                for (int n = 0; n < CACHE_ENTRIES; n++)
                begin
                    k = (start + n) % CACHE_ENTRIES;
                    if (cache_refs[k] != 8'd0)
                    begin
                        r.slot = 4'(k);
                        break;
                    end
                end
            end
        end
        else if (sel < 88)
            r.action = bbct_pkg::ACT_DIRTY;
        else
            r.action = bbct_pkg::ACT_UPTODATE;
        return r;
    endfunction

    // offer one beat, record its expected response once accepted
    task automatic send_request(input bbct_pkg::req_t r, input bit typed,
                                input bbct_pkg::rsp_t typed_rsp);
        bbct_pkg::rsp_t predicted;
        req <= r;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = apply_request(r);
        pending_rsp.push_back(typed ? typed_rsp : predicted);
        // idle cycles before the next beat
        while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++)
            send_request(random_request(), 1'b0, '0);
    endtask

    // stop offering and wait for every outstanding response
    task automatic pause_until_drained();
        if (in_valid)
            in_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    task automatic add_row(input bbct_pkg::action_t a, input logic [7:0] d,
                           input logic [31:0] b, input logic [3:0] s, input bit typed,
                           input bbct_pkg::status_t st, input logic [3:0] e,
                           input bit rd, input bit wk);
        stim_row_t row;
        row.item.action = a;
        row.item.device = d;
        row.item.block_number = b;
        row.item.slot = s;
        row.typed = typed;
        row.result.status = st;
        row.result.entry = e;
        row.result.needs_read = rd;
        row.result.wake_waiters = wk;
        directed_rows.push_back(row);
    endtask

    // compare one response beat with the oldest expectation
    task automatic check_response(input bbct_pkg::rsp_t got);
        bbct_pkg::rsp_t want;
        if (pending_rsp.size() == 0)
        begin
            error_count++;
            if (error_count <= 10)
                $display("%0t unexpected response: status %0d entry %0d rd %0b wk %0b",
                         $time, got.status, got.entry, got.needs_read, got.wake_waiters);
        end
        else
        begin
            want = pending_rsp.pop_front();
            if (got.status !== want.status || got.entry !== want.entry ||
                got.needs_read !== want.needs_read ||
                got.wake_waiters !== want.wake_waiters)
            begin
                error_count++;
                if (error_count <= 10)
                    $display({"%0t mismatch: exp status %0d entry %0d rd %0b wk %0b,",
                              " got status %0d entry %0d rd %0b wk %0b"},
                             $time, want.status, want.entry, want.needs_read,
                             want.wake_waiters, got.status, got.entry, got.needs_read,
                             got.wake_waiters);
            end
        end
    endtask

    // response side: check beats, drive ready with idles and hold-offs
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                check_response(rsp);
            if (rx_hold > 0)
            begin
                rx_hold--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // request side
    initial
    begin
        int             j;
        bbct_pkg::req_t r;
        logic [7:0]     fill_dev;
        logic [31:0]    fill_blk;

        for (int k = 0; k < CACHE_ENTRIES; k++)
        begin
            cache_dev[k] = '0;
            cache_blk[k] = '0;
            cache_refs[k] = '0;
            cache_dirty[k] = 1'b0;
            cache_uptodate[k] = 1'b0;
        end

        // directed table
        // device zero hits an empty entry, then a good release, free-entry releases and marks
        add_row(bbct_pkg::ACT_GET, 8'h00, 32'h0, 4'd0,
                1'b1, bbct_pkg::ST_HIT, 4'd0, 1'b1, 1'b0);
        add_row(bbct_pkg::ACT_RELEASE, 8'h00, 32'h0, 4'd0,
                1'b1, bbct_pkg::ST_HIT, 4'd0, 1'b0, 1'b1);
        add_row(bbct_pkg::ACT_RELEASE, 8'h00, 32'h0, 4'd0,
                1'b1, bbct_pkg::ST_BADREL, 4'd0, 1'b0, 1'b0);
        add_row(bbct_pkg::ACT_RELEASE, 8'hFF, 32'hFFFFFFFF, 4'd15,
                1'b1, bbct_pkg::ST_BADREL, 4'd15, 1'b0, 1'b0);
        add_row(bbct_pkg::ACT_DIRTY, 8'h00, 32'h0, 4'd0,
                1'b1, bbct_pkg::ST_HIT, 4'd0, 1'b0, 1'b0);
        add_row(bbct_pkg::ACT_UPTODATE, 8'h00, 32'h0, 4'd1,
                1'b1, bbct_pkg::ST_HIT, 4'd1, 1'b0, 1'b0);
        // allocate at the extremes, mark a held entry, hit it again
        add_row(bbct_pkg::ACT_GET, 8'hFF, 32'hFFFFFFFF, 4'd0,
                1'b0, bbct_pkg::ST_HIT, 4'd0, 1'b0, 1'b0);
        add_row(bbct_pkg::ACT_UPTODATE, 8'h00, 32'h0, 4'd2,
                1'b1, bbct_pkg::ST_HIT, 4'd2, 1'b0, 1'b0);
        add_row(bbct_pkg::ACT_GET, 8'hFF, 32'hFFFFFFFF, 4'd0,
                1'b0, bbct_pkg::ST_HIT, 4'd0, 1'b0, 1'b0);
        // fill every entry, cheapest first; one miss with device zero
        for (int k = 1; k < CACHE_ENTRIES; k++)
        begin
            fill_dev = (k == 7) ? 8'h00 : 8'(k * 17);
            fill_blk = (k == 7) ? 32'd5 : 32'hA5A5_0000 + k;
            add_row(bbct_pkg::ACT_GET, fill_dev, fill_blk, 4'(k),
                    1'b0, bbct_pkg::ST_HIT, 4'd0, 1'b0, 1'b0);
        end
        // nothing free any more
        add_row(bbct_pkg::ACT_GET, 8'h5A, 32'h12345678, 4'd0,
                1'b1, bbct_pkg::ST_NOFREE, 4'd0, 1'b0, 1'b0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[n])
            send_request(directed_rows[n].item, directed_rows[n].typed,
                         directed_rows[n].result);

        // random, sender lighter idling
        tx_idle_pct = 28;
        rx_idle_pct = 54;
        send_random(40);

        // random, receiver lighter idling
        tx_idle_pct = 54;
        rx_idle_pct = 28;
        send_random(40);

        // no idling; long receiver hold-off to back up the input
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold = 150;
        send_random(10);
        pause_until_drained();
        send_random(25);

        // drive one tag to a saturated count and step it back down
        j = 0;
        for (int k = CACHE_ENTRIES - 1; k >= 0; k--)
            if (cache_refs[k] != 8'd0)
                j = k;
        for (int k = CACHE_ENTRIES - 1; k >= 0; k--)
            if (cache_dev[k] == cache_dev[j] && cache_blk[k] == cache_blk[j])
                j = k;
        r = '0;
        r.action = bbct_pkg::ACT_GET;
        r.device = cache_dev[j];
        r.block_number = cache_blk[j];
        r.slot = 4'(j);
        while (cache_refs[j] != bbct_pkg::COUNT_MAX)
            send_request(r, 1'b0, '0);
        repeat (3)
            send_request(r, 1'b0, '0);
        r.action = bbct_pkg::ACT_RELEASE;
        repeat (3)
            send_request(r, 1'b0, '0);

        pause_until_drained();
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("[block_buffer_cache_tags] OK");
        else
            $display("[block_buffer_cache_tags] ERROR");
        $finish;
    end

endmodule
